@@ hdl/voxel_gradient_normals_assert.svh @@
// assertion macros shared by the voxel gradient normal block
`ifndef VOXEL_GRADIENT_NORMALS_ASSERT_SVH
`define VOXEL_GRADIENT_NORMALS_ASSERT_SVH

// same-cycle implication, inactive during reset
`define VGN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, inactive during reset
`define VGN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/vgn_pkg.sv @@
// types and constants of the voxel gradient normal block
package vgn_pkg;

  localparam int DENS_W = 16;
  localparam int COORD_W = 5;
  localparam int NRM_W = 11;
  localparam int GRAD_W = 17;
  localparam int MAG_W = 16;
  localparam int SQ_W = 32;
  localparam int SUM_W = 34;
  localparam int MA_W = 52;
  localparam int MB_W = 20;
  localparam int T_W = 56;
  localparam int Q_W = 10;

  localparam logic [MB_W-1:0] SCALE_SQ = 20'd1000000;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_SQ    = 8'b0000_1000,
    S_SUM   = 8'b0001_0000,
    S_SCALE = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_NORMAL = 1'b1;

endpackage

@@ hdl/voxel_gradient_normals.sv @@
// voxel density volume with central-difference surface normal queries
//
//   channel | signals                                   | moves
//   in      | in_valid/in_ready, command x y z density  | one write or normal request
//   out     | out_valid/out_ready, normal_x/y/z, zero   | one result per normal request
//
// a write request is taken in idle; a normal request first reads the six neighbors on the
// single read port, then squares each axis bit-serially (one bit of |g| per cycle); for a
// nonzero gradient it then scales each axis by 1e6 and runs a 10-step quotient loop per
// axis, bit by bit
// after reset a clearing pass writes zero to every entry, 2^(3*clog2(min(dim,32))) entries
// (32768 at the default size), with in_ready low
// a finished result waits in the output register while out_ready is low
module voxel_gradient_normals
  import vgn_pkg::*;
#(
  parameter int VOLUME_DIM = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic [COORD_W-1:0]        in_x,
  input  logic [COORD_W-1:0]        in_y,
  input  logic [COORD_W-1:0]        in_z,
  input  logic [DENS_W-1:0]         in_density,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [NRM_W-1:0]   out_normal_x,
  output logic signed [NRM_W-1:0]   out_normal_y,
  output logic signed [NRM_W-1:0]   out_normal_z,
  output logic                      out_zero_gradient
);

  `include "voxel_gradient_normals_assert.svh"

  // only coordinates below 32 can ever be written, so storage covers at most 32 per side
  localparam int SIDE = (VOLUME_DIM < 32) ? VOLUME_DIM : 32;
  localparam int CW = $clog2(SIDE);
  localparam int AW = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [COORD_W:0] SIDE_C = (COORD_W+1)'(SIDE);

  state_t state_r, state_nxt;

  // density memory, one write and one registered read port
  logic [DENS_W-1:0] mem [DEPTH];
  logic [DENS_W-1:0] rd_data_r;
  logic              rd_ok_r;
  logic [AW-1:0]     rd_addr;
  logic              rd_ok;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DENS_W-1:0] wr_data;
  logic [AW-1:0]     clr_cnt_r;

  logic              in_acc;
  logic              wr_inrange;

  // request coordinates and neighbor walk
  logic [COORD_W-1:0] px_r, py_r, pz_r;
  logic [2:0]         rd_cnt_r;
  logic [COORD_W:0]   nx, ny, nz;
  logic [2:0]         rd_j;
  logic [DENS_W-1:0]  nb_val;
  logic [DENS_W-1:0]  plus_r;

  // per-axis values rotate so that entry 0 is always the axis at work
  logic signed [GRAD_W-1:0] g_r [3];
  logic [SQ_W-1:0]          sq_r [3];
  logic signed [NRM_W-1:0]  res_r [3];
  logic [1:0]               comp_r;
  logic [MAG_W-1:0]         mag0, mag1;
  logic [GRAD_W-1:0]        gneg0, gneg1;

  // bit-serial multiplier
  logic [MA_W-1:0] mul_a_r, mul_acc_r;
  logic [MB_W-1:0] mul_b_r;
  logic            mul_done;

  // quotient loop
  logic [SUM_W-1:0] sum_r;
  logic [MA_W-1:0]  rhs_r;
  logic [T_W-1:0]   q2_r, ps_r, ss_r, test;
  logic [Q_W-1:0]   q_r, q_fin;
  logic [3:0]       k_r;
  logic             test_ok;
  logic             zero_r;
  logic             sq_zero;
  logic [NRM_W-1:0] q_ext;
  logic             g0_pos;
  logic signed [NRM_W-1:0] comp_res;

  logic out_valid_r;
  logic out_load;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc = in_valid & in_ready;
  assign out_valid = out_valid_r;

  assign wr_inrange = ({1'b0, in_x} < SIDE_C) && ({1'b0, in_y} < SIDE_C) &&
                      ({1'b0, in_z} < SIDE_C);

  // write port: clearing pass or write request
  always_comb begin
    if (state_r == S_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else begin
      wr_en = in_acc && (in_command == CMD_WRITE) && wr_inrange;
      wr_addr = {in_z[CW-1:0], in_y[CW-1:0], in_x[CW-1:0]};
      wr_data = in_density;
    end
  end

  // neighbor coordinate for the read issued this cycle; minus one at zero wraps out of range
  always_comb begin
    nx = {1'b0, px_r};
    ny = {1'b0, py_r};
    nz = {1'b0, pz_r};
    case (rd_cnt_r)
      3'd0: nx = {1'b0, px_r} + 6'd1;
      3'd1: nx = {1'b0, px_r} - 6'd1;
      3'd2: ny = {1'b0, py_r} + 6'd1;
      3'd3: ny = {1'b0, py_r} - 6'd1;
      3'd4: nz = {1'b0, pz_r} + 6'd1;
      3'd5: nz = {1'b0, pz_r} - 6'd1;
      default: ;
    endcase
    rd_ok = (nx < SIDE_C) && (ny < SIDE_C) && (nz < SIDE_C);
    rd_addr = {nz[CW-1:0], ny[CW-1:0], nx[CW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_ok_r <= rd_ok;
  end

  assign rd_j = rd_cnt_r - 3'd1;
  assign nb_val = rd_ok_r ? rd_data_r : '0;

  // magnitudes of the current and the next axis
  assign gneg0 = -g_r[0];
  assign gneg1 = -g_r[1];
  assign mag0 = g_r[0][GRAD_W-1] ? gneg0[MAG_W-1:0] : g_r[0][MAG_W-1:0];
  assign mag1 = g_r[1][GRAD_W-1] ? gneg1[MAG_W-1:0] : g_r[1][MAG_W-1:0];

  assign mul_done = (mul_b_r == '0);

  // all three squares zero means a zero gradient
  assign sq_zero = (sq_r[0] == '0) && (sq_r[1] == '0) && (sq_r[2] == '0);

  // trial of the next quotient bit: (q + 2^k)^2 * sum against 1e6 * g^2
  assign test = q2_r + ps_r + ss_r;
  assign test_ok = (test <= {{(T_W-MA_W){1'b0}}, rhs_r});
  assign q_fin = test_ok ? (q_r | (Q_W'(1) << k_r)) : q_r;
  assign q_ext = {1'b0, q_fin};
  assign g0_pos = !g_r[0][GRAD_W-1] && (g_r[0] != '0);
  assign comp_res = g0_pos ? -$signed(q_ext) : $signed(q_ext);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (&clr_cnt_r) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc && (in_command == CMD_NORMAL)) state_nxt = S_READ;
      S_READ:  if (rd_cnt_r == 3'd6) state_nxt = S_SQ;
      S_SQ:    if (mul_done && (comp_r == 2'd2)) state_nxt = S_SUM;
      S_SUM:   state_nxt = sq_zero ? S_DONE : S_SCALE;
      S_SCALE: if (mul_done) state_nxt = S_DIV;
      S_DIV: begin
        if (k_r == 4'd0) state_nxt = (comp_r == 2'd2) ? S_DONE : S_SCALE;
      end
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        px_r <= in_x;
        py_r <= in_y;
        pz_r <= in_z;
        rd_cnt_r <= '0;
        comp_r <= '0;
      end
      S_READ: begin
        rd_cnt_r <= rd_cnt_r + 3'd1;
        if (rd_cnt_r != 3'd0) begin
          if (!rd_j[0]) begin
            plus_r <= nb_val;
          end else begin
            g_r[rd_j[2:1]] <= $signed({1'b0, plus_r}) - $signed({1'b0, nb_val});
          end
        end
        if (rd_cnt_r == 3'd6) begin
          // x gradient is final, start its square
          mul_a_r <= MA_W'(mag0);
          mul_b_r <= MB_W'(mag0);
          mul_acc_r <= '0;
        end
      end
      S_SQ: begin
        if (!mul_done) begin
          if (mul_b_r[0]) mul_acc_r <= mul_acc_r + mul_a_r;
          mul_a_r <= mul_a_r << 1;
          mul_b_r <= mul_b_r >> 1;
        end else begin
          sq_r[2] <= mul_acc_r[SQ_W-1:0];
          sq_r[1] <= sq_r[2];
          sq_r[0] <= sq_r[1];
          g_r[0] <= g_r[1];
          g_r[1] <= g_r[2];
          g_r[2] <= g_r[0];
          comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
          mul_a_r <= MA_W'(mag1);
          mul_b_r <= MB_W'(mag1);
          mul_acc_r <= '0;
        end
      end
      S_SUM: begin
        sum_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
        zero_r <= sq_zero;
        mul_a_r <= MA_W'(sq_r[0]);
        mul_b_r <= SCALE_SQ;
        mul_acc_r <= '0;
      end
      S_SCALE: begin
        if (!mul_done) begin
          if (mul_b_r[0]) mul_acc_r <= mul_acc_r + mul_a_r;
          mul_a_r <= mul_a_r << 1;
          mul_b_r <= mul_b_r >> 1;
        end else begin
          rhs_r <= mul_acc_r;
          q_r <= '0;
          q2_r <= '0;
          ps_r <= '0;
          ss_r <= {{(T_W-SUM_W-2*(Q_W-1)){1'b0}}, sum_r, {(2*(Q_W-1)){1'b0}}};
          k_r <= 4'(Q_W-1);
        end
      end
      S_DIV: begin
        // ps holds q*sum << (k+1), ss holds sum << 2k
        q_r <= q_fin;
        if (test_ok) begin
          q2_r <= test;
          ps_r <= (ps_r + (ss_r << 1)) >> 1;
        end else begin
          ps_r <= ps_r >> 1;
        end
        ss_r <= ss_r >> 2;
        k_r <= k_r - 4'd1;
        if (k_r == 4'd0) begin
          res_r[2] <= comp_res;
          res_r[1] <= res_r[2];
          res_r[0] <= res_r[1];
          g_r[0] <= g_r[1];
          g_r[1] <= g_r[2];
          g_r[2] <= g_r[0];
          sq_r[0] <= sq_r[1];
          sq_r[1] <= sq_r[2];
          sq_r[2] <= sq_r[0];
          comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
          mul_a_r <= MA_W'(sq_r[1]);
          mul_b_r <= SCALE_SQ;
          mul_acc_r <= '0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_zero_gradient <= zero_r;
      out_normal_x <= zero_r ? '0 : res_r[0];
      out_normal_y <= zero_r ? '0 : res_r[1];
      out_normal_z <= zero_r ? '0 : res_r[2];
    end
  end

  `VGN_ASSERT_NEXT(a_normal_starts_read, in_acc && (in_command == CMD_NORMAL),
    state_r == S_READ, "normal request did not start the neighbor reads")
  `VGN_ASSERT_NOW(a_zero_flag_zero_normal, out_valid_r && out_zero_gradient,
    (out_normal_x == '0) && (out_normal_y == '0) && (out_normal_z == '0),
    "zero gradient with a nonzero normal")
  `VGN_ASSERT_NOW(a_nonzero_normal, out_valid_r && !out_zero_gradient,
    (out_normal_x != '0) || (out_normal_y != '0) || (out_normal_z != '0),
    "nonzero gradient gave an all-zero normal")
  `VGN_ASSERT_NOW(a_no_write_while_busy, wr_en && (state_r != S_CLEAR),
    state_r == S_IDLE, "memory write outside idle")

endmodule
